// ===== hw/rtl/pse_pkg.sv =====
package pse_pkg;
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] OP_PUSH     = 2'd0;
    localparam logic [1:0] OP_APPLY    = 2'd1;
    localparam logic [1:0] OP_FINISH   = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [7:0] CH_ADD = 8'h2B;
    localparam logic [7:0] CH_SUB = 8'h2D;
    localparam logic [7:0] CH_MUL = 8'h2A;
    localparam logic [7:0] CH_DIV = 8'h2F;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd2;
    localparam logic [2:0] ST_BAD_OP    = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;
    localparam logic [2:0] ST_EMPTY_FIN = 3'd5;

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        begin
            if (v > Q_MAX)      r = 32'h7FFF_FFFF;
            else if (v < Q_MIN) r = 32'h8000_0000;
            else                r = v[31:0];
            return r;
        end
    endfunction
endpackage

// ===== hw/rtl/pse_ram.sv =====
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/pse_div.sv =====
// signed restoring divider, 48-bit dividend, one quotient bit per cycle
module pse_div
    import pse_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [31:0]  i_num,
    input  logic signed [31:0]  i_den,
    output logic                o_done,
    output logic signed [63:0]  o_quot
);
    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [47:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic        r_neg;
    logic        r_done;
    logic [33:0] trial;
    logic [32:0] shifted;

    assign shifted = {r_rem[31:0], r_q[47]};
    assign trial   = {1'b0, shifted} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd47;
                r_q    <= {(i_num[31] ? 32'(-i_num) : 32'(i_num)), 16'h0};
                r_rem  <= '0;
                r_den  <= i_den[31] ? 32'(-i_den) : 32'(i_den);
                r_neg  <= i_num[31] ^ i_den[31];
            end else if (r_busy) begin
                if (!trial[33]) begin
                    r_rem <= trial[32:0];
                    r_q   <= {r_q[46:0], 1'b1};
                end else begin
                    r_rem <= shifted;
                    r_q   <= {r_q[46:0], 1'b0};
                end
                r_busy <= (r_cnt != 6'd0);
                r_cnt  <= r_cnt - 6'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({16'h0, r_q}) : $signed({16'h0, r_q});
endmodule

// ===== hw/rtl/postfix_stack_evaluator.sv =====
// Postfix evaluator on signed Q16.16 operands with a 64-entry operand stack
// held in one RAM with registered read. A request is taken when start is
// high and busy low; exactly one result comes back on a one-cycle o_valid
// strobe and the receiver cannot stall it. A push, an empty finish or an
// unused operation code is answered straight from idle: the strobe follows
// the accepting edge and the next request can be taken at once. A finish
// with entries makes one stack read. Add, subtract and multiply go through
// two stack reads, operand load, registered multiply and write-back; a bad
// operator or a divide by zero ends before write-back. Divide waits on the
// one-bit-per-cycle restoring divider over its 48-bit dividend.
module postfix_stack_evaluator
    import pse_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_value,
    input  logic [7:0]         i_operator_char,
    output logic               o_valid,
    output logic signed [31:0] o_top_value,
    output logic [6:0]         o_depth,
    output logic [2:0]         o_status,
    output logic               o_is_final
);
    typedef enum logic [3:0] {
        S_IDLE, S_RD_B, S_RD_A, S_CALC, S_MUL, S_DIV, S_WB, S_FIN_RD, S_FIN
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [7:0]         r_ch;
    logic signed [31:0] r_a, r_b;
    logic               r_oka, r_okb;
    logic signed [63:0] r_prod;
    logic [CNT_W-1:0]   r_rcnt;
    logic               r_is_mul;
    logic [31:0]        r_res;

    logic               push_we, ram_we;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [31:0]        wdata, rdata;
    logic               div_start, div_done;
    logic signed [63:0] div_q;
    logic signed [63:0] sum;
    logic signed [63:0] mul_r;
    logic [31:0]        wb_val;
    logic               bad_op;

    pse_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    pse_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(r_a), .i_den(r_b), .o_done(div_done), .o_quot(div_q)
    );

    assign busy = (r_state != S_IDLE);
    assign raddr = ADDR_W'(r_rcnt - CNT_W'(1));
    assign bad_op = (r_ch != CH_ADD) && (r_ch != CH_SUB) && (r_ch != CH_MUL)
                    && (r_ch != CH_DIV);
    assign div_start = (r_state == S_CALC) && (r_ch == CH_DIV) && (r_b != '0);

    always_comb begin
        sum = '0;
        case (r_ch)
            CH_ADD:  sum = 64'(r_a) + 64'(r_b);
            CH_SUB:  sum = 64'(r_a) - 64'(r_b);
            default: sum = '0;
        endcase
    end

    // multiply result: round half up, floor by 2^16, saturate
    assign mul_r  = (r_prod + 64'sd32768) >>> 16;
    assign wb_val = r_is_mul ? sat32(mul_r) : r_res;

    // writes: push from idle, operator result at write-back
    assign push_we = (r_state == S_IDLE) && start && (i_operation == OP_PUSH)
                     && (r_cnt < CNT_W'(STACK_DEPTH));
    assign ram_we  = push_we || (r_state == S_WB);
    assign waddr   = r_cnt[ADDR_W-1:0];
    assign wdata   = (r_state == S_WB) ? wb_val : i_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        case (i_operation)
                            OP_PUSH: begin
                                o_valid    <= 1'b1;
                                o_is_final <= 1'b0;
                                if (r_cnt < CNT_W'(STACK_DEPTH)) begin
                                    o_top_value <= i_value;
                                    o_status    <= ST_OK;
                                    o_depth     <= 7'(r_cnt + CNT_W'(1));
                                    r_cnt       <= r_cnt + CNT_W'(1);
                                end else begin
                                    o_top_value <= '0;
                                    o_status    <= ST_OVERFLOW;
                                    o_depth     <= 7'(r_cnt);
                                end
                            end
                            OP_APPLY: begin
                                o_valid <= 1'b0;
                                r_ch    <= i_operator_char;
                                r_rcnt  <= r_cnt;
                                r_state <= S_RD_B;
                            end
                            OP_FINISH: begin
                                if (r_cnt == '0) begin
                                    o_valid     <= 1'b1;
                                    o_top_value <= '0;
                                    o_status    <= ST_EMPTY_FIN;
                                    o_depth     <= '0;
                                    o_is_final  <= 1'b0;
                                end else begin
                                    o_valid <= 1'b0;
                                    r_rcnt  <= r_cnt;
                                    r_state <= S_FIN_RD;
                                end
                            end
                            default: begin
                                o_valid     <= 1'b1;
                                o_top_value <= '0;
                                o_status    <= ST_BAD_OP;
                                o_depth     <= 7'(r_cnt);
                                o_is_final  <= 1'b0;
                            end
                        endcase
                    end else begin
                        o_valid <= 1'b0;
                    end
                end
                S_FIN_RD: begin
                    o_valid <= 1'b0;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    o_valid     <= 1'b1;
                    o_top_value <= rdata;
                    o_status    <= ST_OK;
                    o_is_final  <= 1'b1;
                    o_depth     <= '0;
                    r_cnt       <= '0;
                    r_state     <= S_IDLE;
                end
                S_RD_B: begin
                    // b read issued at r_rcnt-1; step down for a
                    o_valid <= 1'b0;
                    r_okb   <= (r_rcnt != '0);
                    if (r_rcnt != '0) r_rcnt <= r_rcnt - CNT_W'(1);
                    r_state <= S_RD_A;
                end
                S_RD_A: begin
                    o_valid <= 1'b0;
                    r_b     <= r_okb ? rdata : '0;
                    r_oka   <= (r_rcnt != '0);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    o_valid <= 1'b0;
                    r_a     <= r_oka ? rdata : '0;
                    r_cnt   <= r_oka ? r_rcnt - CNT_W'(1) : r_rcnt;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_prod   <= 64'(r_a) * 64'(r_b);
                    r_is_mul <= (r_ch == CH_MUL);
                    r_res    <= sat32(sum);
                    if (bad_op) begin
                        o_valid <= 1'b1; o_status <= ST_BAD_OP;
                        o_top_value <= '0; o_depth <= 7'(r_cnt);
                        o_is_final <= 1'b0;
                        r_state <= S_IDLE;
                    end else if (r_ch == CH_DIV && r_b == '0) begin
                        o_valid <= 1'b1; o_status <= ST_DIV_ZERO;
                        o_top_value <= '0; o_depth <= 7'(r_cnt);
                        o_is_final <= 1'b0;
                        r_state <= S_IDLE;
                    end else if (r_ch == CH_DIV) begin
                        o_valid <= 1'b0;
                        r_state <= S_DIV;
                    end else begin
                        o_valid <= 1'b0;
                        r_state <= S_WB;
                    end
                end
                S_DIV: begin
                    o_valid <= 1'b0;
                    if (div_done) begin
                        r_res   <= sat32(div_q);
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    o_valid     <= 1'b1;
                    o_top_value <= wb_val;
                    o_status    <= (r_oka && r_okb) ? ST_OK : ST_UNDERFLOW;
                    o_is_final  <= 1'b0;
                    o_depth     <= 7'(r_cnt + CNT_W'(1));
                    r_cnt       <= r_cnt + CNT_W'(1);
                    r_state     <= S_IDLE;
                end
                default: begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STACK_DEPTH)) else $error("count past depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy)) else $error("request lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_final |-> o_depth == 7'd0) else $error("final depth");
endmodule
